/* hdl/rcst_pkg.sv */
// shared widths, codes and inter-module types for the session table
package rcst_pkg;

    localparam int unsigned ID_W       = 31;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned PIN_W      = 16;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_USER_W = 4;

    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_PIN_MAX  = 2'd3
    } t_status;

    typedef enum logic {
        FN_ACQUIRE = 1'b0,
        FN_RELEASE = 1'b1
    } t_func;

    // query travelling down the row of cells, with the hit picked up on the way
    typedef struct packed {
        logic             valid;
        t_func            func;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic [PIN_W-1:0] pin;
    } t_probe;

    // entry update broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [ID_W-1:0]  id;
        logic [PIN_W-1:0] pin;
    } t_wr;

endpackage

/* hdl/rcst_cell.sv */
// one table entry: holds id and pin, checks the passing query and hands it on
module rcst_cell import rcst_pkg::*; #(
    parameter int unsigned CELL = 0,
    parameter int unsigned IW   = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_probe        i_probe,
    input  logic [IW-1:0] i_hit_idx,
    output t_probe        o_probe,
    output logic [IW-1:0] o_hit_idx,
    input  t_wr           i_wr,
    input  logic [IW-1:0] i_wr_idx
);

    localparam logic [IW-1:0] OWN = IW'(CELL);

    logic [ID_W-1:0]  r_id;
    logic [PIN_W-1:0] r_pin;
    t_probe           r_probe;
    logic [IW-1:0]    r_hit_idx;
    logic             w_match;
    logic             w_sel;

    assign w_sel = i_wr.en && (i_wr_idx == OWN);

    // an entry with pin zero is free and never matches
    always_comb begin
        w_match = 1'b0;
        if (i_probe.valid && !i_probe.hit && (r_pin != '0)) begin
            if (i_probe.func == FN_ACQUIRE) begin
                w_match = (r_id == i_probe.id);
            end else begin
                w_match = (32'(i_probe.idx) == CELL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin   <= '0;
            r_probe <= '0;
        end else begin
            if (w_sel) begin
                r_pin <= i_wr.pin;
            end
            r_probe <= i_probe;
            if (w_match) begin
                r_probe.hit <= 1'b1;
                r_probe.pin <= r_pin;
            end
        end
    end

    // the id is only taken when a free entry is claimed
    always_ff @(posedge i_clk) begin
        if (w_sel && (r_pin == '0)) begin
            r_id <= i_wr.id;
        end
        r_hit_idx <= w_match ? OWN : i_hit_idx;
    end

    assign o_probe   = r_probe;
    assign o_hit_idx = r_hit_idx;

endmodule

/* hdl/rcst_free_stack.sv */
// free-list memory with a low-water mark standing in for the reset fill
module rcst_free_stack #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_pop,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_wr_data,
    output logic [AW-1:0] o_top
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_q;
    logic [AW-1:0] r_seed;
    logic [AW-1:0] r_addr;
    logic          r_fresh;
    logic [CW-1:0] r_low;

    // slots below the lowest depth reached were never pushed: they still hold
    // their reset index
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_addr];
            r_seed  <= AW'(DEPTH - 1) - i_rd_addr;
            r_addr  <= i_rd_addr;
            r_fresh <= (CW'(i_rd_addr) < r_low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= CW'(DEPTH);
        end else if (i_pop && r_fresh) begin
            r_low <= CW'(r_addr);
        end
    end

    assign o_top = r_fresh ? r_seed : r_q;

endmodule

/* hdl/refcounted_session_table.sv */
// Reference-counted session table: ENTRIES entries, each in a cell of its own holding a
// session id and a 16-bit pin count, with a last-in first-out free list kept in a memory.
// Every item, acquire or release, is passed down the row of cells one cell per cycle: it goes
// into the head register and through the register of each cell along the row, is decided at
// the end of the row into the result register, and then moves to the output register. Only one
// item is in flight; a new item is taken as soon as the previous result has gone to the
// output register, even while that result waits. No clearing pass after reset.
module refcounted_session_table import rcst_pkg::*; #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // session_id[30:0], entry_index[36:31], zero
    input  logic [0:0]            i_s_axis_tuser,  // func[0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // entry_out[5:0], pin_after[21:6],
                                                   // in_use_count[28:22], zero
    output logic [OUT_USER_W-1:0] o_m_axis_tuser   // status[1:0], entry_freed[2],
                                                   // newly_allocated[3]
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    t_probe                r_head;
    logic [CW-1:0]         r_free_cnt;
    logic [CW-1:0]         r_used_cnt;
    t_wr                   r_wr;
    logic [IW-1:0]         r_wr_idx;
    logic [OUT_DATA_W-1:0] r_res_data;
    logic [OUT_USER_W-1:0] r_res_user;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    t_probe        w_chain   [ENTRIES+1];
    logic [IW-1:0] w_hit_idx [ENTRIES+1];
    t_probe        w_tail;
    logic [IW-1:0] w_tail_idx;
    logic [IW-1:0] w_top;
    logic          w_accept;
    logic          w_decide;

    logic [CW-1:0]    n_free_cnt;
    logic [CW-1:0]    n_used_cnt;
    t_wr              n_wr;
    logic [IW-1:0]    n_wr_idx;
    t_status          n_status;
    logic [IDX_W-1:0] n_entry;
    logic [PIN_W-1:0] n_pin;
    logic             n_freed;
    logic             n_fresh;
    logic             n_pop;
    logic             n_push;

    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_chain[0]   = r_head;
    assign w_hit_idx[0] = '0;
    assign w_tail       = w_chain[ENTRIES];
    assign w_tail_idx   = w_hit_idx[ENTRIES];
    assign w_decide     = (r_state == S_SCAN) && w_tail.valid;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rcst_cell #(
            .CELL (g),
            .IW   (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_probe   (w_chain[g]),
            .i_hit_idx (w_hit_idx[g]),
            .o_probe   (w_chain[g+1]),
            .o_hit_idx (w_hit_idx[g+1]),
            .i_wr      (r_wr),
            .i_wr_idx  (r_wr_idx)
        );
    end

    // top of stack is read at acceptance and is ready long before the decision
    rcst_free_stack #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && (r_free_cnt != '0)),
        .i_rd_addr (IW'(r_free_cnt - 1'b1)),
        .i_pop     (n_pop),
        .i_wr_en   (n_push),
        .i_wr_addr (IW'(r_free_cnt)),
        .i_wr_data (w_tail_idx),
        .o_top     (w_top)
    );

    always_comb begin
        n_free_cnt = r_free_cnt;
        n_used_cnt = r_used_cnt;
        n_wr       = '0;
        n_wr_idx   = w_tail_idx;
        n_status   = ST_OK;
        n_entry    = '0;
        n_pin      = '0;
        n_freed    = 1'b0;
        n_fresh    = 1'b0;
        n_pop      = 1'b0;
        n_push     = 1'b0;
        if (w_decide) begin
            if (w_tail.func == FN_ACQUIRE) begin
                if (w_tail.hit) begin
                    n_entry = IDX_W'(w_tail_idx);
                    if (w_tail.pin == PIN_MAX) begin
                        n_status = ST_PIN_MAX;
                        n_pin    = PIN_MAX;
                    end else begin
                        n_pin    = w_tail.pin + 1'b1;
                        n_wr.en  = 1'b1;
                        n_wr.id  = w_tail.id;
                        n_wr.pin = n_pin;
                    end
                end else if (r_free_cnt == '0) begin
                    n_status = ST_FULL;
                end else begin
                    n_pop      = 1'b1;
                    n_fresh    = 1'b1;
                    n_free_cnt = r_free_cnt - 1'b1;
                    n_used_cnt = r_used_cnt + 1'b1;
                    n_entry    = IDX_W'(w_top);
                    n_pin      = PIN_W'(1);
                    n_wr.en    = 1'b1;
                    n_wr.id    = w_tail.id;
                    n_wr.pin   = n_pin;
                    n_wr_idx   = w_top;
                end
            end else begin
                if (!w_tail.hit) begin
                    n_status = ST_NOT_USED;
                    n_entry  = w_tail.idx;
                end else begin
                    n_entry  = IDX_W'(w_tail_idx);
                    n_pin    = w_tail.pin - 1'b1;
                    n_wr.en  = 1'b1;
                    n_wr.id  = w_tail.id;
                    n_wr.pin = n_pin;
                    if (n_pin == '0) begin
                        n_freed = 1'b1;
                        if (r_free_cnt < CW'(ENTRIES)) begin
                            n_push     = 1'b1;
                            n_free_cnt = r_free_cnt + 1'b1;
                        end
                        if (r_used_cnt != '0) begin
                            n_used_cnt = r_used_cnt - 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free_cnt  <= CW'(ENTRIES);
            r_used_cnt  <= '0;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head.valid <= 1'b0;
            r_wr.en      <= 1'b0;
            if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_head.valid <= 1'b1;
                        r_head.func  <= t_func'(i_s_axis_tuser[0]);
                        r_head.id    <= i_s_axis_tdata[ID_W-1:0];
                        r_head.idx   <= i_s_axis_tdata[ID_W+IDX_W-1:ID_W];
                        r_head.hit   <= 1'b0;
                        r_head.pin   <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_decide) begin
                        r_free_cnt <= n_free_cnt;
                        r_used_cnt <= n_used_cnt;
                        r_wr       <= n_wr;
                        r_wr_idx   <= n_wr_idx;
                        r_res_data <= {3'b000, CNT_W'(n_used_cnt), n_pin, n_entry};
                        r_res_user <= {n_fresh, n_freed, n_status};
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_data;
                        r_out_user  <= r_res_user;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

/* hdl/rcst_checker.sv */
// port-level checks for the session table, bound to the top level
module rcst_checker import rcst_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // one item at a time: no second accept right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    // a full table reports entry zero with pin zero and neither flag set
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ST_FULL)) |->
            ((o_m_axis_tdata[21:0] == '0) && (o_m_axis_tuser[3:2] == 2'b00)))
        else $error("full status with nonzero entry or pin");

    // fresh entries start with one pin, freed ones end at zero, both only on success
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((!o_m_axis_tuser[3] || ((o_m_axis_tuser[1:0] == ST_OK)
                                     && (o_m_axis_tdata[21:6] == 16'd1)))
             && (!o_m_axis_tuser[2] || ((o_m_axis_tuser[1:0] == ST_OK)
                                        && (o_m_axis_tdata[21:6] == 16'd0)))))
        else $error("allocation or free flag inconsistent with result");

endmodule

bind refcounted_session_table rcst_checker u_rcst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* tb/refcounted_session_table_checker.sv */
// session table checker: watches both item channels, predicts each reply and compares it
module refcounted_session_table_checker import rcst_pkg::*; #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // session_id[30:0], entry_index[36:31], zero
    input  logic [0:0]            i_s_tuser,   // func[0]
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // entry_out[5:0], pin_after[21:6],
                                               // in_use_count[28:22], zero
    input  logic [OUT_USER_W-1:0] i_m_tuser,   // status[1:0], entry_freed[2],
                                               // newly_allocated[3]
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] entry;
        logic [PIN_W-1:0] pin;
        logic             freed;
        logic             fresh;
        logic [CNT_W-1:0] in_use;
    } t_table_reply;

    localparam logic [31:0] NO_SESSION = '1;

    // own copy of the table
    logic [31:0]      session_ids [ENTRIES];
    logic [PIN_W-1:0] pin_counts  [ENTRIES];
    logic [IDX_W-1:0] free_list   [ENTRIES];
    int unsigned      free_depth;
    int unsigned      sessions_held;

    t_table_reply expected_replies [$];
    int           mismatch_count;

    initial begin
        mismatch_count = 0;
    end

    function automatic t_table_reply make_reply(t_status st, int unsigned entry,
                                                logic [PIN_W-1:0] pin, logic freed,
                                                logic fresh);
        t_table_reply r;
        r.status = st;
        r.entry  = entry[IDX_W-1:0];
        r.pin    = pin;
        r.freed  = freed;
        r.fresh  = fresh;
        r.in_use = sessions_held[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_table_reply apply_table_op(t_func fn, logic [ID_W-1:0] id,
                                                    logic [IDX_W-1:0] idx);
        int unsigned slot;
        bit          found;
        found = 1'b0;
        slot  = 0;
        if (fn == FN_ACQUIRE) begin
            for (int unsigned i = 0; i < ENTRIES; i++) begin
                if (!found && pin_counts[i] != '0 && session_ids[i] == {1'b0, id}) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                if (pin_counts[slot] == PIN_MAX)
                    return make_reply(ST_PIN_MAX, slot, PIN_MAX, 1'b0, 1'b0);
                pin_counts[slot] = pin_counts[slot] + 1'b1;
                return make_reply(ST_OK, slot, pin_counts[slot], 1'b0, 1'b0);
            end
            if (free_depth == 0)
                return make_reply(ST_FULL, 0, '0, 1'b0, 1'b0);
            free_depth--;
            slot = free_list[free_depth];
            session_ids[slot] = {1'b0, id};
            pin_counts[slot]  = 1;
            sessions_held++;
            return make_reply(ST_OK, slot, 1, 1'b0, 1'b1);
        end
        if (idx >= ENTRIES || pin_counts[idx] == '0)
            return make_reply(ST_NOT_USED, idx, '0, 1'b0, 1'b0);
        pin_counts[idx] = pin_counts[idx] - 1'b1;
        if (pin_counts[idx] != '0)
            return make_reply(ST_OK, idx, pin_counts[idx], 1'b0, 1'b0);
        session_ids[idx] = NO_SESSION;
        if (free_depth < ENTRIES) begin
            free_list[free_depth] = idx;
            free_depth++;
        end
        if (sessions_held > 0)
            sessions_held--;
        return make_reply(ST_OK, idx, '0, 1'b1, 1'b0);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_table_reply want;
        t_table_reply got;
        if (!i_rst_n) begin
            for (int unsigned i = 0; i < ENTRIES; i++) begin
                session_ids[i] = NO_SESSION;
                pin_counts[i]  = '0;
                free_list[i]   = IDX_W'(ENTRIES - 1 - i);
            end
            free_depth    = ENTRIES;
            sessions_held = 0;
            expected_replies.delete();
        end else begin
            // replies first: a reply leaving on this edge belongs to an older item
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser[1:0]);
                got.freed  = i_m_tuser[2];
                got.fresh  = i_m_tuser[3];
                got.entry  = i_m_tdata[5:0];
                got.pin    = i_m_tdata[21:6];
                got.in_use = i_m_tdata[28:22];
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none actual status %0d entry %0d",
                             $realtime, got.status, got.entry);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("entry_out", want.entry, got.entry);
                    check_field("pin_after", want.pin, got.pin);
                    check_field("entry_freed", want.freed, got.freed);
                    check_field("newly_allocated", want.fresh, got.fresh);
                    check_field("in_use_count", want.in_use, got.in_use);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_replies.push_back(apply_table_op(t_func'(i_s_tuser[0]),
                                                          i_s_tdata[30:0], i_s_tdata[36:31]));
        end
        o_pending <= expected_replies.size();
        o_errors  <= mismatch_count;
    end

endmodule

/* tb/refcounted_session_table_tb.sv */
// session table testbench top: clock, reset, item stimulus, reply back-pressure and verdict
module refcounted_session_table_tb;
    import rcst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_SIZE    = 64;
    localparam int          IDLE_LIMIT    = 1000;
    localparam int          SETTLE_CYCLES = TABLE_SIZE + 20;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [0:0]            s_user  = '0;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    int errors;
    int pending;
    bit quiet = 1'b0;   // no gaps on either side while set
    int stall_left = 0;
    int stall_draw;
    int idle_cycles = 0;

    logic [ID_W-1:0] id_pool [64];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    refcounted_session_table #(.ENTRIES(TABLE_SIZE)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    refcounted_session_table_checker #(.ENTRIES(TABLE_SIZE)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (o_s_axis_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .i_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (m_ready),
        .i_m_tdata  (o_m_axis_tdata),
        .i_m_tuser  (o_m_axis_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // reply side: a fresh random stall, possibly none, after every reply taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_ready && o_m_axis_tvalid) begin
            stall_draw = quiet ? 0 : $urandom_range(0, 3);
            if (stall_draw != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_draw - 1;
            end
        end else if (!m_ready) begin
            if (stall_left == 0)
                m_ready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_table_op(t_func fn, logic [ID_W-1:0] id, logic [IDX_W-1:0] idx);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {3'b000, idx, id};
        s_user  <= fn;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic acquire(logic [ID_W-1:0] id);
        send_table_op(FN_ACQUIRE, id, IDX_W'($urandom));
    endtask

    task automatic release_entry(logic [IDX_W-1:0] idx);
        send_table_op(FN_RELEASE, ID_W'($urandom), idx);
    endtask

    // sender holds off until every reply is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // wide_ids draws fresh ids from the whole range, otherwise ids repeat from a small pool
    task automatic run_mix(int count, int pool, int acquire_pct, int release_hi,
                           bit wide_ids, bit no_gaps);
        quiet = no_gaps;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < acquire_pct) begin
                if (wide_ids)
                    acquire(ID_W'($urandom));
                else
                    acquire(id_pool[$urandom_range(0, pool - 1)]);
            end else begin
                release_entry(IDX_W'($urandom_range(0, release_hi)));
            end
        end
        wait_drained();
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 64; i++)
            id_pool[i] = ID_W'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme ids, hit, pin down to zero, free-list reuse, releases of free entries
        acquire('0);
        acquire('1);
        acquire('0);
        release_entry(0);
        release_entry(0);
        release_entry(0);
        release_entry(6'd63);
        acquire(31'h2AAA_AAAA);
        acquire(31'h5555_5555);
        acquire('1);
        release_entry(1);
        release_entry(1);
        release_entry(1);
        release_entry(2);
        release_entry(0);
        release_entry(6'd42);
        wait_drained();

        // random: small pools for deep pins, fill past full, then drain and mix
        run_mix(150, 4, 60, 5, 1'b0, 1'b0);
        run_mix(150, 16, 70, 19, 1'b0, 1'b1);
        run_mix(130, 64, 95, 63, 1'b1, 1'b0);
        run_mix(190, 8, 10, 63, 1'b0, 1'b0);
        run_mix(130, 32, 50, 63, 1'b0, 1'b0);

        quiet = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* refcounted_session_table.f */
hdl/rcst_pkg.sv
hdl/rcst_cell.sv
hdl/rcst_free_stack.sv
hdl/refcounted_session_table.sv
hdl/rcst_checker.sv
tb/refcounted_session_table_checker.sv
tb/refcounted_session_table_tb.sv
